@@ rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared types, micro-operations, jump conditions and the control store
// program for the modular exponentiation sequencer.
// ----------------------------------------------------------------------------
package modexp_pkg;

	// Datapath micro-operations
	typedef enum logic [3:0] {
		OP_NOP          = 4'd0,
		OP_LOAD         = 4'd1,   // capture base and exponent, result := 1
		OP_CHECK        = 4'd2,   // latch zero-modulus error flag
		OP_RED_INIT     = 4'd3,   // clear remainder, load bit counter
		OP_RED_STEP     = 4'd4,   // one restoring step of base mod m
		OP_SQ_FROM_ACC  = 4'd5,   // square := reduced base
		OP_MUL_INIT     = 4'd6,   // clear accumulator, multiplier := square
		OP_DBL          = 4'd7,   // acc := 2*acc mod m
		OP_ADD_RES      = 4'd8,   // acc := acc + result mod m when bit set
		OP_ADD_SQ       = 4'd9,   // acc := acc + square mod m when bit set
		OP_RES_FROM_ACC = 4'd10,  // result := product
		OP_SQ_NEXT      = 4'd11,  // square := product, drop exponent bit
		OP_EMIT         = 4'd12   // write the output register
	} op_t;

	// Jump conditions: when true, the step counter takes the target
	typedef enum logic [2:0] {
		C_NEVER     = 3'd0,
		C_ALWAYS    = 3'd1,
		C_NO_INPUT  = 3'd2,
		C_MZERO     = 3'd3,
		C_EZERO     = 3'd4,
		C_EBIT_CLR  = 3'd5,
		C_CNT_NZ    = 3'd6,
		C_OUT_BUSY  = 3'd7
	} cond_t;

	localparam int unsigned PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	// Program steps
	localparam pc_t ST_IDLE     = 4'd0;
	localparam pc_t ST_CHECK    = 4'd1;
	localparam pc_t ST_RED_INIT = 4'd2;
	localparam pc_t ST_RED      = 4'd3;
	localparam pc_t ST_RED_END  = 4'd4;
	localparam pc_t ST_LOOP     = 4'd5;
	localparam pc_t ST_TEST     = 4'd6;
	localparam pc_t ST_MR_INIT  = 4'd7;
	localparam pc_t ST_MR_DBL   = 4'd8;
	localparam pc_t ST_MR_ADD   = 4'd9;
	localparam pc_t ST_MR_END   = 4'd10;
	localparam pc_t ST_MS_INIT  = 4'd11;
	localparam pc_t ST_MS_DBL   = 4'd12;
	localparam pc_t ST_MS_ADD   = 4'd13;
	localparam pc_t ST_MS_END   = 4'd14;
	localparam pc_t ST_FIN      = 4'd15;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
		logic  take;     // step accepts an input word
	} ctl_word_t;

	typedef struct packed {
		logic in_valid;
		logic m_zero;
		logic e_zero;
		logic e_bit0;
		logic cnt_nz;
		logic out_busy;
	} dp_status_t;

	// Control store
	function automatic ctl_word_t rom_word(input pc_t pc);
		ctl_word_t w;
		w = '{op: OP_NOP, cond: C_NEVER, target: ST_IDLE, take: 1'b0};
		unique case (pc)
			ST_IDLE:     w = '{OP_LOAD,         C_NO_INPUT, ST_IDLE,   1'b1};
			ST_CHECK:    w = '{OP_CHECK,        C_MZERO,    ST_FIN,    1'b0};
			ST_RED_INIT: w = '{OP_RED_INIT,     C_NEVER,    ST_IDLE,   1'b0};
			ST_RED:      w = '{OP_RED_STEP,     C_CNT_NZ,   ST_RED,    1'b0};
			ST_RED_END:  w = '{OP_SQ_FROM_ACC,  C_NEVER,    ST_IDLE,   1'b0};
			ST_LOOP:     w = '{OP_NOP,          C_EZERO,    ST_FIN,    1'b0};
			ST_TEST:     w = '{OP_NOP,          C_EBIT_CLR, ST_MS_INIT, 1'b0};
			ST_MR_INIT:  w = '{OP_MUL_INIT,     C_NEVER,    ST_IDLE,   1'b0};
			ST_MR_DBL:   w = '{OP_DBL,          C_NEVER,    ST_IDLE,   1'b0};
			ST_MR_ADD:   w = '{OP_ADD_RES,      C_CNT_NZ,   ST_MR_DBL, 1'b0};
			ST_MR_END:   w = '{OP_RES_FROM_ACC, C_NEVER,    ST_IDLE,   1'b0};
			ST_MS_INIT:  w = '{OP_MUL_INIT,     C_NEVER,    ST_IDLE,   1'b0};
			ST_MS_DBL:   w = '{OP_DBL,          C_NEVER,    ST_IDLE,   1'b0};
			ST_MS_ADD:   w = '{OP_ADD_SQ,       C_CNT_NZ,   ST_MS_DBL, 1'b0};
			ST_MS_END:   w = '{OP_SQ_NEXT,      C_ALWAYS,   ST_LOOP,   1'b0};
			ST_FIN:      w = '{OP_EMIT,         C_OUT_BUSY, ST_FIN,    1'b0};
			default:     w = '{OP_NOP,          C_ALWAYS,   ST_IDLE,   1'b0};
		endcase
		return w;
	endfunction

endpackage

@@ rtl/modexp_seq.sv @@
// ----------------------------------------------------------------------------
// modexp_seq
// Step counter and control store: fetches one control word per cycle and
// resolves conditional jumps from datapath status.
// ----------------------------------------------------------------------------
module modexp_seq
	import modexp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output ctl_word_t  cw
);

	pc_t  pc_q;
	logic jump;

	assign cw = rom_word(pc_q);

	// Evaluate the jump condition of the current step
	always_comb begin
		unique case (cw.cond)
			C_NEVER:    jump = 1'b0;
			C_ALWAYS:   jump = 1'b1;
			C_NO_INPUT: jump = !status.in_valid;
			C_MZERO:    jump = status.m_zero;
			C_EZERO:    jump = status.e_zero;
			C_EBIT_CLR: jump = !status.e_bit0;
			C_CNT_NZ:   jump = status.cnt_nz;
			C_OUT_BUSY: jump = status.out_busy;
			default:    jump = 1'b0;
		endcase
	end

	// Advance or jump; the final step falls through to idle by wrapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else if (jump) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + pc_t'(1);
		end
	end

endmodule

@@ rtl/modexp_dp.sv @@
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: modulus register, operand registers, one shared add/reduce
// unit for modular doubling, addition and base reduction, and the output
// register.
// ----------------------------------------------------------------------------
module modexp_dp
	import modexp_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_word_t   cw,
	output dp_status_t  status,
	input  logic        in_valid,
	input  logic [31:0] base,
	input  logic [31:0] exponent,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] power,
	output logic        modulus_error
);

	localparam int unsigned CW = $clog2(WIDTH);

	logic [31:0]      modulus_q;
	logic [WIDTH-1:0] m;
	logic [WIDTH-1:0] sq_q;
	logic [WIDTH-1:0] e_q;
	logic [WIDTH-1:0] res_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] mb_q;
	logic [CW-1:0]    cnt_q;
	logic             err_q;
	logic             out_valid_q;
	logic [31:0]      power_q;
	logic             err_out_q;

	logic             load;
	logic             out_busy;
	logic [WIDTH:0]   sum;
	logic [WIDTH:0]   red;
	logic [WIDTH-1:0] acc_next;

	assign m        = WIDTH'(modulus_q);
	assign load     = cw.take && in_valid;
	assign out_busy = out_valid_q && !out_ready;

	assign status.in_valid = in_valid;
	assign status.m_zero   = (m == '0);
	assign status.e_zero   = (e_q == '0);
	assign status.e_bit0   = e_q[0];
	assign status.cnt_nz   = (cnt_q != '0);
	assign status.out_busy = out_busy;

	// Shared add and conditional subtract of the modulus
	always_comb begin
		unique case (cw.op)
			OP_DBL:      sum = {acc_q, 1'b0};
			OP_RED_STEP: sum = {acc_q, mb_q[WIDTH-1]};
			OP_ADD_RES:  sum = {1'b0, acc_q} + (mb_q[WIDTH-1] ? {1'b0, res_q} : '0);
			OP_ADD_SQ:   sum = {1'b0, acc_q} + (mb_q[WIDTH-1] ? {1'b0, sq_q} : '0);
			default:     sum = {1'b0, acc_q};
		endcase
		red      = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
		acc_next = red[WIDTH-1:0];
	end

	// Hold the modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= '0;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	// Operand registers
	always_ff @(posedge clk) begin
		unique case (cw.op)
			OP_LOAD: begin
				if (load) begin
					mb_q  <= WIDTH'(base);
					e_q   <= WIDTH'(exponent);
					res_q <= WIDTH'(1);
				end
			end
			OP_CHECK: begin
				err_q <= (m == '0);
			end
			OP_RED_INIT: begin
				acc_q <= '0;
				cnt_q <= CW'(WIDTH - 1);
			end
			OP_RED_STEP: begin
				acc_q <= acc_next;
				mb_q  <= {mb_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			OP_SQ_FROM_ACC: begin
				sq_q <= acc_q;
			end
			OP_MUL_INIT: begin
				acc_q <= '0;
				mb_q  <= sq_q;
				cnt_q <= CW'(WIDTH - 1);
			end
			OP_DBL: begin
				acc_q <= acc_next;
			end
			OP_ADD_RES, OP_ADD_SQ: begin
				acc_q <= acc_next;
				mb_q  <= {mb_q[WIDTH-2:0], 1'b0};
				cnt_q <= cnt_q - CW'(1);
			end
			OP_RES_FROM_ACC: begin
				res_q <= acc_q;
			end
			OP_SQ_NEXT: begin
				sq_q <= acc_q;
				e_q  <= {1'b0, e_q[WIDTH-1:1]};
			end
			default: begin
			end
		endcase
	end

	// Output register: fill on emit when free, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cw.op == OP_EMIT && !out_busy) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cw.op == OP_EMIT && !out_busy) begin
			power_q   <= err_q ? '0 : 32'(res_q);
			err_out_q <= err_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign power         = power_q;
	assign modulus_error = err_out_q;

endmodule

@@ rtl/modular_exponentiation_top.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Right-to-left binary modular exponentiation run by a microcoded
// sequencer over a shift-and-add modular multiply datapath.
//
//   channel | signals                        | direction
//   --------+--------------------------------+----------
//   input   | in_valid, in_ready, base,      | in
//           | exponent                       |
//   output  | out_valid, out_ready, power,   | out
//           | modulus_error                  |
//   config  | cfg_we, cfg_wdata (modulus)    | in
//
// One word at a time. A zero modulus jumps from the check step straight
// to the final step. Otherwise the base is reduced mod m, then for each
// exponent bit up to the last set one the result is multiplied by the
// square when the bit is set and the square is squared; the modular
// multiply does one doubling and one addition step per multiplier bit
// through a single add/reduce unit. A finished word waits in the output
// register while the next input word is taken; the sequencer holds on
// its last step only while that register is still full. Reset clears
// the modulus to zero and returns the step counter to idle.
// ----------------------------------------------------------------------------
module modular_exponentiation_top
	import modexp_pkg::*;
#(
	parameter int unsigned WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] base,
	input  logic [31:0] exponent,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] power,
	output logic        modulus_error,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	ctl_word_t  cw;
	dp_status_t status;

	modexp_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cw     (cw)
	);

	modexp_dp #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cw            (cw),
		.status        (status),
		.in_valid      (in_valid),
		.base          (base),
		.exponent      (exponent),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.power         (power),
		.modulus_error (modulus_error)
	);

	assign in_ready = cw.take;

	// One word in flight: no second accept right after the first
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	// Error words always carry a zero power
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && modulus_error) |-> (power == '0))
		else $error("error word with nonzero power");

	// A new result only appears while the sequencer is busy
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result emitted from idle");

endmodule
